/* hw/rtl/lpfp_pkg.sv */
// Shared types and constants of the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned HeadBytesDefault  = 5;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned LenW              = 32;
  localparam int unsigned KindW             = 2;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned CfgDataW          = 8;

  localparam logic [ByteW-1:0] PingTypeReset = 8'd1;
  localparam logic [ByteW-1:0] PongTypeReset = 8'd2;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_REQ   = 2'd0,
    KIND_PONG  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PING_TYPE = 1'b0,
    CFG_PONG_TYPE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] ping_type;
    logic [ByteW-1:0] pong_type;
  } cfg_t;

  // One queued command: a body byte, a whole pong reply or an empty marker.
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic             last;
  } cmd_t;

endpackage

/* hw/rtl/lpfp_in_if.sv */
// Receive byte channel: valid/ready handshake with one byte per word.
interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/lpfp_out_if.sv */
// Result channel: valid/ready handshake carrying one output word.
interface lpfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [31:0] frame_length;
  logic        is_last;

  modport source (output valid, output out_kind, output out_byte, output frame_length,
                  output is_last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input frame_length,
                input is_last, output ready);
endinterface

/* hw/rtl/lpfp_front.sv */
// Front end: header collection, frame classification and body/skip tracking.
module lpfp_front #(
  parameter int unsigned HEAD_BYTES = lpfp_pkg::HeadBytesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpfp_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  input  logic [lpfp_pkg::ByteW-1:0]  in_byte_i,
  output logic                        in_ready_o,
  input  logic                        q_full_i,
  output logic                        push_o,
  output lpfp_pkg::cmd_t              cmd_o
);
  import lpfp_pkg::*;

  localparam int unsigned HcW = $clog2(HEAD_BYTES + 1);

  phase_e           phase_q, phase_d;
  logic [HcW-1:0]   hc_q, hc_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d;

  logic             accept;
  logic [HcW-1:0]   hc_eff;
  logic [HcW-1:0]   hc_inc;
  logic [HcW-1:0]   hc_prev;
  logic [LenW-1:0]  acc_new;
  logic [LenW-1:0]  rem_dec;
  logic             body_last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    type_d    = type_q;
    len_d     = len_q;
    rem_d     = rem_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    hc_eff    = (phase_q == PH_HEAD) ? hc_q : '0;
    hc_inc    = hc_eff + HcW'(1);
    hc_prev   = hc_eff - HcW'(1);
    rem_dec   = rem_q - LenW'(1);
    body_last = (rem_q <= LenW'(1));
    acc_new   = '0;
    if (hc_eff != '0) begin
      acc_new = len_q | (LenW'(in_byte_i) << {hc_prev[1:0], 3'b000});
    end

    if (accept) begin
      unique case (phase_q)
        PH_BODY: begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_REQ;
          cmd_o.data = in_byte_i;
          cmd_o.len  = len_q;
          cmd_o.last = body_last;
          rem_d      = rem_dec;
          if (body_last) begin
            rem_d   = '0;
            phase_d = PH_HEAD;
          end
        end
        PH_SKIP: begin
          rem_d = rem_dec;
          // drop ping body bytes; a zero count also ends the skip
          if (rem_dec == '0 || rem_dec == '1) begin
            rem_d   = '0;
            phase_d = PH_HEAD;
          end
        end
        default: begin
          phase_d = PH_HEAD;
          len_d   = acc_new;
          hc_d    = hc_inc;
          if (hc_eff == '0) begin
            type_d = in_byte_i;
          end
          if (hc_inc == HcW'(HEAD_BYTES)) begin
            hc_d = '0;
            if (type_q == cfg_i.ping_type) begin
              push_o     = 1'b1;
              cmd_o.kind = KIND_PONG;
              cmd_o.data = cfg_i.pong_type;
              if (acc_new != '0) begin
                rem_d   = acc_new;
                phase_d = PH_SKIP;
              end
            end else if (acc_new == '0) begin
              push_o     = 1'b1;
              cmd_o.kind = KIND_EMPTY;
              cmd_o.last = 1'b1;
            end else begin
              rem_d   = acc_new;
              phase_d = PH_BODY;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      hc_q    <= '0;
      type_q  <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      type_q  <= type_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

/* hw/rtl/lpfp_queue.sv */
// Small command queue between front and back end.
module lpfp_queue #(
  parameter int unsigned DEPTH = lpfp_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpfp_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lpfp_pkg::cmd_t cmd_o
);
  import lpfp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* hw/rtl/lpfp_back.sv */
// Back end: expands pong commands into reply bytes and drives the output register.
module lpfp_back #(
  parameter int unsigned HEAD_BYTES = lpfp_pkg::HeadBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lpfp_pkg::cmd_t q_cmd_i,
  output logic           pop_o,
  lpfp_out_if.source     out_o
);
  import lpfp_pkg::*;

  localparam int unsigned BeatW = $clog2(HEAD_BYTES);

  logic [BeatW-1:0] beat_q, beat_d;
  logic             valid_q, valid_d;
  cmd_t             word_q, word_d;
  logic             advance;
  logic             load;

  assign advance = !valid_q || out_o.ready;

  always_comb begin
    beat_d = beat_q;
    word_d = q_cmd_i;
    pop_o  = 1'b0;
    load   = advance && q_valid_i;
    if (load) begin
      unique case (q_cmd_i.kind)
        KIND_PONG: begin
          word_d.data = (beat_q == '0) ? q_cmd_i.data : '0;
          word_d.len  = '0;
          word_d.last = (beat_q == BeatW'(HEAD_BYTES - 1));
          if (word_d.last) begin
            pop_o  = 1'b1;
            beat_d = '0;
          end else begin
            beat_d = beat_q + BeatW'(1);
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
    valid_d = load ? 1'b1 : (advance ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_kind     = word_q.kind;
  assign out_o.out_byte     = word_q.data;
  assign out_o.frame_length = word_q.len;
  assign out_o.is_last      = word_q.last;

endmodule

/* hw/rtl/length_prefixed_frame_parser_top.sv */
// Top level of the length-prefixed frame parser with heartbeat reply.
//
// Usage: in_i carries one received stream byte per word (rx_byte). Each frame
// starts with a header of HEAD_BYTES bytes: a type byte, then the body length,
// least significant byte first. out_o carries result words: request body bytes
// (kind 0) tagged with the frame length and a last flag, pong reply bytes
// (kind 1, HEAD_BYTES words per ping header) and an empty-request marker
// (kind 2) for a request header of zero length. Ping bodies are dropped.
// The config port writes the ping type code (index 0) and pong type code
// (index 1); write it only while no frame is in flight.
//
// Throughput: one input byte per cycle. A ping header turns into HEAD_BYTES
// output words, one per cycle while out_o.ready is high; the command queue
// (QUEUE_DEPTH entries) soaks up that burst, and in_i.ready drops only when the
// queue is full. Each result word passes through a queue slot and then the
// back end output register before it is offered.
// Stall: when out_o.ready is low the output word holds and the queue fills;
// once it is full in_i.ready goes low. Reset clears all frame state, empties
// the queue and loads the default type codes (ping 1, pong 2).
module length_prefixed_frame_parser_top #(
  parameter int unsigned HEAD_BYTES  = lpfp_pkg::HeadBytesDefault,
  parameter int unsigned QUEUE_DEPTH = lpfp_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lpfp_in_if.sink                       in_i,
  lpfp_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [lpfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpfp_pkg::CfgDataW-1:0] cfg_data_i
);
  import lpfp_pkg::*;

  cfg_t cfg_q;
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_out;

  // Config registers: decode the index, hold everything else.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_type <= PingTypeReset;
      cfg_q.pong_type <= PongTypeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PING_TYPE: cfg_q.ping_type <= cfg_data_i;
        CFG_PONG_TYPE: cfg_q.pong_type <= cfg_data_i;
      endcase
    end
  end

  // Front end: collect headers, classify frames, track body/skip counts.
  lpfp_front #(
    .HEAD_BYTES (HEAD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.rx_byte),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  // Decouple front and back so each side stalls on its own.
  lpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  // Back end: expand pong replies, register each output word.
  lpfp_back #(
    .HEAD_BYTES (HEAD_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_out),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

/* hw/rtl/lpfp_checker.sv */
// Port-level checker for the frame parser, bound to the top level.
module lpfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic [31:0] out_length_i,
  input logic        out_last_i
);
  import lpfp_pkg::*;

  logic out_fire;
  assign out_fire = out_valid_i && out_ready_i;

  // A stalled output word must stay offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // Pong reply bytes carry no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_PONG |-> out_length_i == '0)
    else $error("pong word with nonzero length");

  // An empty-request marker is a single closing word with zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_EMPTY |->
      out_last_i && out_byte_i == '0 && out_length_i == '0)
    else $error("malformed empty-request marker");

  // A pong reply runs back to back until its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_kind_i == KIND_PONG && !out_last_i |=>
      out_valid_i && out_kind_i == KIND_PONG)
    else $error("pong reply interrupted");

  // Only the three defined kinds appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      out_kind_i == KIND_REQ || out_kind_i == KIND_PONG || out_kind_i == KIND_EMPTY)
    else $error("undefined output kind");

endmodule

bind length_prefixed_frame_parser_top lpfp_checker u_lpfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.out_kind),
  .out_byte_i   (out_o.out_byte),
  .out_length_i (out_o.frame_length),
  .out_last_i   (out_o.is_last)
);
